### rtl/xcfr_pkg.sv
// xcfr_pkg: shared types and codes for the XOR-checked frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package xcfr_pkg;

  // Sequencer states of the controller
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_LEN,
    ST_RD_DATA
  } ctrl_state_t;

  // Frame parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SUM     = 3'd3,
    PH_TAIL    = 3'd4
  } parse_phase_t;

  // Input command codes
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_FEED  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Feed event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_COMMIT     = 3'd1;
  localparam logic [2:0] EV_SUM_ERR    = 3'd2;
  localparam logic [2:0] EV_RING_FULL  = 3'd3;
  localparam logic [2:0] EV_LEN_REJECT = 3'd4;

  // Register indexes (paddr[2]) and reset values
  localparam logic       REG_HEAD   = 1'b0;
  localparam logic       REG_TAIL   = 1'b1;
  localparam logic [7:0] HEAD_RESET = 8'hAA;
  localparam logic [7:0] TAIL_RESET = 8'h55;

  // Payload index width per slot (frames hold at most 62 bytes)
  localparam int IDX_W = 6;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept_feed;   // feed beat taken, run the parser
    logic read_empty;    // read beat taken on an empty ring
    logic start_read;    // read beat taken, ring holds a frame
    logic load_len;      // latch length of the oldest frame
    logic emit;          // load one frame data beat into the output register
  } xcfr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;      // output register can take a beat this cycle
    logic ring_empty;
    logic emit_last;     // the next data beat ends the frame
  } xcfr_sts_t;

endpackage

`default_nettype wire

### rtl/xcfr_ifs.sv
// xcfr_in_if / xcfr_out_if: valid/ready channels of the frame receiver.
// No dependencies.
`default_nettype none

interface xcfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface xcfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [5:0] frame_length;
  logic       last;

  modport source (output valid, kind, event_res, data_byte, frame_length, last,
                  input ready);
  modport sink   (input valid, kind, event_res, data_byte, frame_length, last,
                  output ready);
endinterface

`default_nettype wire

### rtl/xcfr_regs.sv
// xcfr_regs: APB-style register file holding the head and tail byte values.
// Depends on xcfr_pkg.
`default_nettype none

module xcfr_regs
  import xcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       head_byte,
  output logic [7:0]       tail_byte
);

  logic [7:0] head_r, head_nxt;
  logic [7:0] tail_r, tail_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_HEAD: head_nxt = pwdata[7:0];
        REG_TAIL: tail_nxt = pwdata[7:0];
        default:  head_nxt = head_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
      tail_r <= TAIL_RESET;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEAD: prdata = {24'd0, head_r};
      REG_TAIL: prdata = {24'd0, tail_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign head_byte = head_r;
  assign tail_byte = tail_r;

endmodule

`default_nettype wire

### rtl/xcfr_ctrl.sv
// xcfr_ctrl: sequencer that takes input beats and paces frame readout.
// Depends on xcfr_pkg.
`default_nettype none

module xcfr_ctrl
  import xcfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_command,
  output logic            in_ready,
  input  wire xcfr_sts_t  sts,
  output xcfr_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        take;

  assign take = (state_r == ST_IDLE) && in_valid && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && (in_command == CMD_READ) && !sts.ring_empty) state_nxt = ST_RD_LEN;
      end
      ST_RD_LEN:  state_nxt = ST_RD_DATA;
      ST_RD_DATA: begin
        if (sts.out_free && sts.emit_last) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready         = sts.out_free;
        cmd.accept_feed  = take && (in_command == CMD_FEED);
        cmd.read_empty   = take && (in_command == CMD_READ) && sts.ring_empty;
        cmd.start_read   = take && (in_command == CMD_READ) && !sts.ring_empty;
      end
      ST_RD_LEN:  cmd.load_len = 1'b1;
      ST_RD_DATA: cmd.emit     = sts.out_free;
      default:    cmd          = '0;
    endcase
  end

  // Final data beat hands control back to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> (state_r == ST_IDLE))
    else $error("readout did not end after last beat");

  // Nothing is taken while a frame is being streamed out
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(cmd.accept_feed || cmd.read_empty || cmd.start_read))
    else $error("input beat taken during readout");

  // Only one command kind per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

### rtl/xcfr_dpath.sv
// xcfr_dpath: frame parser, slot ring with payload and length memories,
// readout counters and output register. Depends on xcfr_pkg.
`default_nettype none

module xcfr_dpath
  import xcfr_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int MAX_LENGTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire xcfr_cmd_t  cmd,
  output xcfr_sts_t       sts,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] head_byte,
  input  wire logic [7:0] tail_byte,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [2:0]      out_event_res,
  output logic [7:0]      out_data_byte,
  output logic [5:0]      out_frame_length,
  output logic            out_last
);

  localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PAY_DEPTH = SLOTS << IDX_W;
  localparam logic [SW-1:0]    SLOT_TOP  = SW'(SLOTS - 1);
  localparam logic [7:0]       LEN_LIMIT = 8'(MAX_LENGTH - 1);
  localparam logic [IDX_W-1:0] LEN_CLAMP = IDX_W'(MAX_LENGTH - 2);

  // Parser state
  parse_phase_t     phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [IDX_W-1:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [IDX_W-1:0] flen_r, flen_nxt;
  logic [SW-1:0]    wr_slot_r, wr_slot_nxt;
  logic [2:0]       ev;
  logic             pay_we, len_we;

  // Readout state
  logic [SW-1:0]    rd_slot_r, rd_slot_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] rd_len_r, rd_len_nxt;
  logic [IDX_W-1:0] len_q_r;
  logic [7:0]       pay_q_r;

  // Output register
  logic             ov_r, ov_nxt;
  logic [1:0]       okind_r, okind_nxt;
  logic [2:0]       oev_r, oev_nxt;
  logic [7:0]       odata_r, odata_nxt;
  logic [5:0]       olen_r, olen_nxt;
  logic             olast_r, olast_nxt;

  // Memories
  logic [7:0]       pay_mem [PAY_DEPTH];
  logic [IDX_W-1:0] len_mem [SLOTS];

  logic [SW-1:0]    w_inc, r_inc;
  logic             ring_full, ring_empty, emit_last;
  logic [IDX_W-1:0] cnt_inc;

  assign w_inc      = (wr_slot_r == SLOT_TOP) ? '0 : wr_slot_r + 1'b1;
  assign r_inc      = (rd_slot_r == SLOT_TOP) ? '0 : rd_slot_r + 1'b1;
  assign ring_full  = (w_inc == rd_slot_r);
  assign ring_empty = (wr_slot_r == rd_slot_r);
  assign cnt_inc    = rcv_cnt_r + 1'b1;
  assign emit_last  = (rd_len_r == '0) || ((rd_idx_r + 1'b1) == rd_len_r);

  assign sts.out_free   = !ov_r || out_ready;
  assign sts.ring_empty = ring_empty;
  assign sts.emit_last  = emit_last;

  // ---------------- parser ----------------
  always_comb begin
    phase_nxt   = phase_r;
    xor_nxt     = xor_r;
    rcv_cnt_nxt = rcv_cnt_r;
    flen_nxt    = flen_r;
    wr_slot_nxt = wr_slot_r;
    ev          = EV_NONE;
    pay_we      = 1'b0;
    len_we      = 1'b0;
    if (cmd.accept_feed) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == head_byte) begin
            if (ring_full) ev = EV_RING_FULL;
            else           phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte < LEN_LIMIT) begin
            len_we      = 1'b1;
            flen_nxt    = rx_byte[IDX_W-1:0];
            rcv_cnt_nxt = '0;
            xor_nxt     = '0;
            phase_nxt   = (rx_byte == 8'd0) ? PH_SUM : PH_PAYLOAD;
          end else begin
            phase_nxt = PH_HUNT;
            ev        = EV_LEN_REJECT;
          end
        end
        PH_PAYLOAD: begin
          pay_we      = 1'b1;
          xor_nxt     = xor_r ^ rx_byte;
          rcv_cnt_nxt = cnt_inc;
          if (cnt_inc == flen_r) phase_nxt = PH_SUM;
        end
        PH_SUM: begin
          if (xor_r == rx_byte) begin
            phase_nxt = PH_TAIL;
          end else begin
            phase_nxt = PH_HUNT;
            ev        = EV_SUM_ERR;
          end
        end
        PH_TAIL: begin
          if (rx_byte == tail_byte) begin
            wr_slot_nxt = w_inc;
            phase_nxt   = PH_HUNT;
            ev          = EV_COMMIT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // ---------------- readout ----------------
  always_comb begin
    rd_slot_nxt = rd_slot_r;
    rd_idx_nxt  = rd_idx_r;
    rd_len_nxt  = rd_len_r;
    if (cmd.start_read) rd_idx_nxt = '0;
    if (cmd.load_len)   rd_len_nxt = (len_q_r > LEN_CLAMP) ? LEN_CLAMP : len_q_r;
    if (cmd.emit) begin
      if (emit_last) begin
        rd_idx_nxt  = '0;
        rd_slot_nxt = r_inc;
      end else begin
        rd_idx_nxt  = rd_idx_r + 1'b1;
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    okind_nxt = okind_r;
    oev_nxt   = oev_r;
    odata_nxt = odata_r;
    olen_nxt  = olen_r;
    olast_nxt = olast_r;
    priority if (cmd.accept_feed) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_FEED;
      oev_nxt   = ev;
      odata_nxt = 8'd0;
      olen_nxt  = 6'd0;
      olast_nxt = 1'b1;
    end else if (cmd.read_empty) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_EMPTY;
      oev_nxt   = EV_NONE;
      odata_nxt = 8'd0;
      olen_nxt  = 6'd0;
      olast_nxt = 1'b1;
    end else if (cmd.emit) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_DATA;
      oev_nxt   = EV_NONE;
      odata_nxt = (rd_len_r == '0) ? 8'd0 : pay_q_r;
      olen_nxt  = rd_len_r;
      olast_nxt = emit_last;
    end else begin
      ov_nxt    = ov_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      xor_r     <= '0;
      rcv_cnt_r <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      rd_idx_r  <= '0;
      ov_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      xor_r     <= xor_nxt;
      rcv_cnt_r <= rcv_cnt_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      rd_idx_r  <= rd_idx_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    flen_r   <= flen_nxt;
    rd_len_r <= rd_len_nxt;
    okind_r  <= okind_nxt;
    oev_r    <= oev_nxt;
    odata_r  <= odata_nxt;
    olen_r   <= olen_nxt;
    olast_r  <= olast_nxt;
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[{wr_slot_r, rcv_cnt_r}] <= rx_byte;
  end

  always_ff @(posedge clk) begin
    pay_q_r <= pay_mem[{rd_slot_r, rd_idx_nxt}];
  end

  // Length memory
  always_ff @(posedge clk) begin
    if (len_we) len_mem[wr_slot_r] <= flen_nxt;
  end

  always_ff @(posedge clk) begin
    len_q_r <= len_mem[rd_slot_r];
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_event_res    = oev_r;
  assign out_data_byte    = odata_r;
  assign out_frame_length = olen_r;
  assign out_last         = olast_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_slot_r <= SLOT_TOP) && (rd_slot_r <= SLOT_TOP))
    else $error("slot pointer out of range");

  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept_feed && (ev == EV_COMMIT)) |=> (wr_slot_r != rd_slot_r))
    else $error("commit overran the ring");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_read |-> !ring_empty)
    else $error("readout started on empty ring");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(odata_r) && $stable(okind_r)))
    else $error("stalled output beat overwritten");

endmodule

`default_nettype wire

### rtl/xor_checked_frame_receiver.sv
// xor_checked_frame_receiver: top level of the framed byte receiver.
// Depends on xcfr_pkg, xcfr_ifs, xcfr_regs, xcfr_ctrl, xcfr_dpath.
//
// Usage:
//  - in_ch carries one beat per command: command 0 feeds rx_byte to the frame
//    parser (head, length, payload, XOR checksum, tail), command 1 reads the
//    oldest stored frame.
//  - out_ch returns results. A feed gives one status beat (kind 0, event code,
//    last 1). A read gives the frame's payload beats (kind 1) with last on the
//    final one, a single kind 1 beat of zero data for an empty frame, or one
//    kind 2 beat when the ring is empty.
//  - Timing: a feed result is in the output register in the cycle after the
//    beat is taken. A read of an L byte frame first waits in the length-load
//    state (ST_RD_LEN) for the registered length fetch, then streams one beat
//    per cycle while out_ch does not stall. A feed or empty read leaves the
//    controller idle; a read of a stored frame keeps it busy to its last beat.
//  - The controller takes one input beat at a time; in_ready is high while
//    idle and the output register is empty or being drained.
//  - A stall on out_ch holds the current beat and pauses readout; nothing is
//    lost. Reset clears the parser, ring pointers and output register; stored
//    payloads are not cleared and no clearing pass is needed.
//  - The APB-style port sets head (0x0) and tail (0x4) byte values; write
//    only while idle.
`default_nettype none

module xor_checked_frame_receiver
  import xcfr_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int MAX_LENGTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  xcfr_in_if.sink          in_ch,
  xcfr_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  xcfr_cmd_t  cmd;
  xcfr_sts_t  sts;
  logic [7:0] head_byte;
  logic [7:0] tail_byte;

  xcfr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .head_byte (head_byte),
    .tail_byte (tail_byte)
  );

  // Sequencer: decides which beat is taken and when readout advances
  xcfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Parser, slot ring and output register
  xcfr_dpath #(
    .SLOTS      (SLOTS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .rx_byte          (in_ch.rx_byte),
    .head_byte        (head_byte),
    .tail_byte        (tail_byte),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_kind         (out_ch.kind),
    .out_event_res    (out_ch.event_res),
    .out_data_byte    (out_ch.data_byte),
    .out_frame_length (out_ch.frame_length),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for xor_checked_frame_receiver.
// Needs xcfr_pkg and the xcfr_in_if / xcfr_out_if interfaces from the RTL.
// Runs directed frame cases, then random framed traffic under three idling mixes.

module testbench;
  import xcfr_pkg::*;

  localparam int SLOTS   = 8;
  localparam int MAX_LEN = 64;

  localparam logic [2:0] ADDR_HEAD = {REG_HEAD, 2'b00};
  localparam logic [2:0] ADDR_TAIL = {REG_TAIL, 2'b00};

  // One result beat as the block presents it on out_ch
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] ev;
    logic [7:0] data;
    logic [5:0] len;
    logic       last;
  } result_beat_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xcfr_in_if  in_ch ();
  xcfr_out_if out_ch ();

  xor_checked_frame_receiver #(
    .SLOTS      (SLOTS),
    .MAX_LENGTH (MAX_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the receiver: registers, parser and the frame ring
  // ---------------------------------------------------------------------------
  logic [7:0]   head_val;
  logic [7:0]   tail_val;
  parse_phase_t phase;
  logic [7:0]   xor_acc;
  logic [5:0]   rx_count;
  int unsigned  wr_slot;
  int unsigned  rd_slot;
  logic [5:0]   slot_len  [SLOTS];
  logic [7:0]   frame_mem [SLOTS][MAX_LEN];

  // Result beats the block still owes, oldest first
  result_beat_t owed_beats [$];

  // Idle odds, in percent, for the sending and the receiving side
  int unsigned send_gap_pct;
  int unsigned take_gap_pct;

  int unsigned errors;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned frames_committed;
  int unsigned frames_read;
  int unsigned cfg_writes;

  // Parser step for one received byte; returns the feed event code
  function automatic logic [2:0] parse_rx_byte(input logic [7:0] b);
    logic [2:0] ev;
    ev = EV_NONE;
    case (phase)
      PH_HUNT: begin
        if (b == head_val) begin
          // one slot stays unused: full when the write slot would hit the read slot
          if ((wr_slot + 1) % SLOTS == rd_slot) ev = EV_RING_FULL;
          else phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < MAX_LEN - 1) begin
          slot_len[wr_slot] = b[5:0];
          rx_count = '0;
          xor_acc  = '0;
          // a zero length skips the payload and checks against an XOR of zero
          phase = (b == 8'd0) ? PH_SUM : PH_PAYLOAD;
        end else begin
          phase = PH_HUNT;
          ev    = EV_LEN_REJECT;
        end
      end
      PH_PAYLOAD: begin
        frame_mem[wr_slot][rx_count] = b;
        xor_acc  = xor_acc ^ b;
        rx_count = rx_count + 6'd1;
        if (rx_count == slot_len[wr_slot]) phase = PH_SUM;
      end
      PH_SUM: begin
        if (xor_acc == b) begin
          phase = PH_TAIL;
        end else begin
          phase = PH_HUNT;
          ev    = EV_SUM_ERR;
        end
      end
      PH_TAIL: begin
        // anything but the tail byte is dropped while waiting
        if (b == tail_val) begin
          wr_slot = (wr_slot + 1) % SLOTS;
          phase   = PH_HUNT;
          ev      = EV_COMMIT;
          frames_committed++;
        end
      end
      default: phase = PH_HUNT;
    endcase
    return ev;
  endfunction

  // Read command: queue the oldest frame's beats, or the empty-ring beat
  function automatic void unload_frame();
    int n;
    if (rd_slot == wr_slot) begin
      owed_beats.push_back(result_beat_t'{KIND_EMPTY, EV_NONE, 8'h00, 6'd0, 1'b1});
      return;
    end
    n = slot_len[rd_slot];
    if (n == 0) begin
      // zero-length frame still returns one data beat of zero
      owed_beats.push_back(result_beat_t'{KIND_DATA, EV_NONE, 8'h00, 6'd0, 1'b1});
    end else begin
      for (int i = 0; i < n; i++)
        owed_beats.push_back(result_beat_t'{KIND_DATA, EV_NONE, frame_mem[rd_slot][i],
                                            slot_len[rd_slot], (i == n - 1)});
    end
    rd_slot = (rd_slot + 1) % SLOTS;
    frames_read++;
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_slot + SLOTS - rd_slot) % SLOTS;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiving side and result checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial out_ch.ready = 1'b0;

  // Receiver drops ready at random; held low through reset
  always @(posedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= take_gap_pct);

  result_beat_t got;
  result_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = result_beat_t'{out_ch.kind, out_ch.event_res, out_ch.data_byte,
                           out_ch.frame_length, out_ch.last};
      if (owed_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat kind=%0d ev=%0d data=%02h len=%0d last=%0d",
                 $time, got.kind, got.ev, got.data, got.len, got.last);
      end else begin
        want = owed_beats.pop_front();
        beats_checked++;
        if (got.kind !== want.kind || got.ev !== want.ev || got.data !== want.data ||
            got.len !== want.len || got.last !== want.last) begin
          errors++;
          $display("%0t: result mismatch exp kind=%0d ev=%0d data=%02h len=%0d last=%0d",
                   $time, want.kind, want.ev, want.data, want.len, want.last);
          $display("%0t:                 got kind=%0d ev=%0d data=%02h len=%0d last=%0d",
                   $time, got.kind, got.ev, got.data, got.len, got.last);
        end
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Present one input beat, wait for the handshake, then predict its results.
  // valid stays high on return so back-to-back beats need no extra assignment.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (cmd == CMD_FEED)
      owed_beats.push_back(result_beat_t'{KIND_FEED, parse_rx_byte(b), 8'h00, 6'd0, 1'b1});
    else
      unload_frame();
  endtask

  // Lower valid and let every owed beat drain; the block is idle afterwards
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle until pready, then psel and penable drop
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [7:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= {24'h0, wdata};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_framing(input logic [7:0] head, input logic [7:0] tail);
    logic [31:0] unused;
    cfg_access(1'b1, ADDR_HEAD, head, unused);
    head_val = head;
    cfg_access(1'b1, ADDR_TAIL, tail, unused);
    tail_val = tail;
    cfg_writes += 2;
  endtask

  task automatic check_framing();
    logic [31:0] rd_head;
    logic [31:0] rd_tail;
    cfg_access(1'b0, ADDR_HEAD, 8'h00, rd_head);
    cfg_access(1'b0, ADDR_TAIL, 8'h00, rd_tail);
    if (rd_head[7:0] !== head_val || rd_tail[7:0] !== tail_val) begin
      errors++;
      $display("%0t: register readback exp head=%02h tail=%02h got head=%02h tail=%02h",
               $time, head_val, tail_val, rd_head[7:0], rd_tail[7:0]);
    end
  endtask

  // Whole frame: head, length, payload, checksum, optional junk, tail.
  // bad_sum flips checksum bits; alt_fill uses 00/FF payload instead of random.
  task automatic send_frame(input int len, input bit bad_sum, input int junk, input bit alt_fill);
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] j;
    sum = 8'h00;
    send_item(CMD_FEED, head_val);
    send_item(CMD_FEED, len[7:0]);
    for (int i = 0; i < len; i++) begin
      pb  = alt_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
      sum = sum ^ pb;
      send_item(CMD_FEED, pb);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    send_item(CMD_FEED, sum);
    for (int i = 0; i < junk; i++) begin
      j = 8'($urandom);
      if (j == tail_val) j = j ^ 8'h01;
      send_item(CMD_FEED, j);
    end
    send_item(CMD_FEED, tail_val);
  endtask

  task automatic read_frame();
    send_item(CMD_READ, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, then both extremes written and read back
  task automatic test_register_access();
    check_framing();
    write_framing(8'h00, 8'hFF);
    check_framing();
    write_framing(8'hFF, 8'h00);
    check_framing();
    write_framing(HEAD_RESET, TAIL_RESET);
    check_framing();
  endtask

  task automatic test_empty_read();
    read_frame();
    wait_idle();
  endtask

  // Zero, one and the longest accepted length, read back in order
  task automatic test_frame_shapes();
    send_frame(0, 1'b0, 0, 1'b0);
    send_frame(1, 1'b0, 0, 1'b0);
    send_frame(MAX_LEN - 2, 1'b0, 0, 1'b1);
    repeat (4) read_frame();
    wait_idle();
  endtask

  // Rejected lengths, checksum error, stray bytes while waiting for the tail
  task automatic test_parse_errors();
    send_item(CMD_FEED, head_val);
    send_item(CMD_FEED, 8'(MAX_LEN - 1));
    send_item(CMD_FEED, head_val);
    send_item(CMD_FEED, 8'hFF);
    send_frame(3, 1'b1, 0, 1'b0);
    send_frame(2, 1'b0, 2, 1'b0);
    repeat (2) read_frame();
    wait_idle();
  endtask

  // Fill all usable slots, then a head byte must report ring full
  task automatic test_ring_full();
    repeat (SLOTS - 1) send_frame(0, 1'b0, 0, 1'b0);
    send_item(CMD_FEED, head_val);
    repeat (SLOTS) read_frame();
    wait_idle();
  endtask

  // Framing bytes at their extremes
  task automatic test_framing_bytes();
    write_framing(8'h00, 8'hFF);
    send_frame(2, 1'b0, 1, 1'b0);
    read_frame();
    wait_idle();
    write_framing(8'hFF, 8'h00);
    send_frame(1, 1'b0, 0, 1'b0);
    read_frame();
    wait_idle();
    write_framing(HEAD_RESET, TAIL_RESET);
  endtask

  // Mostly well-formed frames with random content, mixed with reads,
  // rejected lengths and noise bytes. Reads get likelier as the ring fills.
  task automatic test_random_traffic(input int unsigned n, input int unsigned src_gap,
                                     input int unsigned snk_gap);
    int unsigned start;
    int unsigned read_pct;
    int unsigned r;
    int          len;
    send_gap_pct = src_gap;
    take_gap_pct = snk_gap;
    start = beats_sent;
    while (beats_sent - start < n) begin
      read_pct = (ring_fill() >= SLOTS - 2) ? 50 : (ring_fill() == 0) ? 5 : 20;
      r = $urandom_range(99);
      if (r < read_pct) begin
        read_frame();
      end else if (r < read_pct + 10) begin
        send_item(CMD_FEED, 8'($urandom));
      end else if (r < read_pct + 14) begin
        send_item(CMD_FEED, head_val);
        send_item(CMD_FEED, 8'($urandom_range(255, MAX_LEN - 1)));
      end else begin
        r = $urandom_range(99);
        len = (r < 80) ? $urandom_range(6, 0) :
              (r < 95) ? $urandom_range(20, 7) : $urandom_range(MAX_LEN - 2, 21);
        send_frame(len, ($urandom_range(9) == 0),
                   ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0, 1'b0);
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors           = 0;
    beats_sent       = 0;
    beats_checked    = 0;
    frames_committed = 0;
    frames_read      = 0;
    cfg_writes       = 0;
    send_gap_pct     = 27;
    take_gap_pct     = 53;

    head_val = HEAD_RESET;
    tail_val = TAIL_RESET;
    phase    = PH_HUNT;
    xor_acc  = '0;
    rx_count = '0;
    wr_slot  = 0;
    rd_slot  = 0;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_FEED;
    in_ch.rx_byte = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_empty_read();
    test_frame_shapes();
    test_parse_errors();
    test_ring_full();
    test_framing_bytes();

    // three idling mixes, framing bytes changed between them
    test_random_traffic(32, 27, 53);
    write_framing(8'($urandom), 8'($urandom));
    check_framing();
    test_random_traffic(32, 53, 27);
    write_framing(8'($urandom), 8'($urandom));
    test_random_traffic(32, 0, 0);

    // drain, then watch for stray beats for longer than a full frame readout
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);

    $display("covered %0d input beats, %0d result beats checked, %0d register writes",
             beats_sent, beats_checked, cfg_writes);
    $display("frames committed %0d, frames read back %0d, errors %0d",
             frames_committed, frames_read, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
